>>> design/tar_pkg.sv
`default_nettype none
package tar_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int DIM_BITS_DEF    = 12;

  localparam int TDATA_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_REG_W = 13;
  localparam int MODE_W    = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_N = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_W = 3'd4;

  localparam logic [MODE_W-1:0] MODE_N   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_C   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_H   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_W_AX = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALL = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NC  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CH  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_HW  = 3'd7;

  // per-item control carried from front to back
  typedef struct packed {
    logic elem;
    logic first;
    logic last;
    logic tend;
    logic ok;
  } tar_flags_t;

  localparam int FLAGS_W = $bits(tar_flags_t);

  // reduced axes, bit 3 n, bit 2 c, bit 1 h, bit 0 w
  function automatic logic [3:0] red_mask(input logic [MODE_W-1:0] mode);
    logic [3:0] m;
    case (mode)
      MODE_N:    m = 4'b1000;
      MODE_C:    m = 4'b0100;
      MODE_H:    m = 4'b0010;
      MODE_W_AX: m = 4'b0001;
      MODE_ALL:  m = 4'b1111;
      MODE_NC:   m = 4'b1100;
      MODE_CH:   m = 4'b0110;
      MODE_HW:   m = 4'b0011;
      default:   m = 4'b1111;
    endcase
    return m;
  endfunction

  // kept axes inside the outermost reduced axis
  function automatic logic [3:0] grp_mask(input logic [MODE_W-1:0] mode);
    logic [3:0] m;
    case (mode)
      MODE_N:          m = 4'b0111;
      MODE_C, MODE_NC: m = 4'b0011;
      MODE_H, MODE_CH: m = 4'b0001;
      default:         m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> design/tar_front.sv
`default_nettype none
module tar_front #(
  parameter int STORE_DEPTH = tar_pkg::STORE_DEPTH_DEF,
  parameter int DIM_BITS    = tar_pkg::DIM_BITS_DEF,
  parameter int AW          = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tar_pkg::DIM_REG_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_bit,
  input  wire logic                           q_full,
  output logic                                push,
  output tar_pkg::tar_flags_t                 push_flags,
  output logic [AW-1:0]                       push_addr
);
  import tar_pkg::*;

  localparam int EW = DIM_BITS + 1;
  localparam int SW = (3 * EW > 18) ? 3 * EW : 18;
  localparam logic [EW-1:0] DMAX = EW'(1) << DIM_BITS;

  logic [MODE_W-1:0]    mode_r;
  logic [DIM_REG_W-1:0] dim_n_r, dim_c_r, dim_h_r, dim_w_r;
  logic [DIM_BITS-1:0]  pos_r [4];
  logic [AW-1:0]        cnt_r;
  logic [1:0]           settle_r;
  logic [2*EW-1:0]      hw_r;
  logic [3*EW-1:0]      chw_r;
  logic                 ok_r;

  logic [EW-1:0] eff [4];
  logic [3:0]    at_max, at_zero, red, grp;
  logic          cfg_hit, group_wrap;
  logic [SW-1:0] span;

  function automatic logic [EW-1:0] eff_dim(input logic [DIM_REG_W-1:0] d);
    logic [EW-1:0] r;
    if (d == '0) begin
      r = EW'(1);
    end else if (32'(d) > (32'(1) << DIM_BITS)) begin
      r = DMAX;
    end else begin
      r = EW'(d);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= CFG_DIM_W);

  assign eff[0] = eff_dim(dim_n_r);
  assign eff[1] = eff_dim(dim_c_r);
  assign eff[2] = eff_dim(dim_h_r);
  assign eff[3] = eff_dim(dim_w_r);

  // at_max bit 3 is n, bit 0 is w
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      at_max[3-a]  = ({1'b0, pos_r[a]} + EW'(1)) >= eff[a];
      at_zero[3-a] = (pos_r[a] == '0);
    end
  end

  assign red        = red_mask(mode_r);
  assign grp        = grp_mask(mode_r);
  assign group_wrap = &(~grp | at_max);

  always_comb begin
    case (mode_r)
      MODE_N:          span = SW'(chw_r);
      MODE_C, MODE_NC: span = SW'(hw_r);
      MODE_H, MODE_CH: span = SW'(eff[3]);
      default:         span = SW'(1);
    endcase
  end

  assign in_ready         = !q_full && (settle_r == 2'd0);
  assign push             = in_valid && in_ready;
  assign push_flags.elem  = in_bit;
  assign push_flags.first = &(~red | at_zero);
  assign push_flags.last  = &(~red | at_max);
  assign push_flags.tend  = &at_max;
  assign push_flags.ok    = ok_r;
  assign push_addr        = cnt_r;

  always_ff @(posedge clk) begin
    hw_r  <= eff[2] * eff[3];
    chw_r <= eff[1] * hw_r;
    ok_r  <= span <= SW'(STORE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ALL;
      dim_n_r  <= DIM_REG_W'(1);
      dim_c_r  <= DIM_REG_W'(1);
      dim_h_r  <= DIM_REG_W'(1);
      dim_w_r  <= DIM_REG_W'(1);
      cnt_r    <= '0;
      settle_r <= 2'd3;
      for (int a = 0; a < 4; a++) begin
        pos_r[a] <= '0;
      end
    end else if (cfg_hit) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[MODE_W-1:0];
        CFG_DIM_N: dim_n_r <= cfg_data;
        CFG_DIM_C: dim_c_r <= cfg_data;
        CFG_DIM_H: dim_h_r <= cfg_data;
        CFG_DIM_W: dim_w_r <= cfg_data;
        default:   ;
      endcase
      cnt_r    <= '0;
      settle_r <= 2'd3;
      for (int a = 0; a < 4; a++) begin
        pos_r[a] <= '0;
      end
    end else begin
      if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
      if (push) begin
        cnt_r <= group_wrap ? '0 : cnt_r + AW'(1);
        // w fastest; an axis steps when every inner axis wraps
        for (int a = 0; a < 4; a++) begin
          if (&(at_max | ~((4'b1 << (3 - a)) - 4'b1))) begin
            pos_r[a] <= at_max[3-a] ? '0 : pos_r[a] + DIM_BITS'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/tar_queue.sv
`default_nettype none
module tar_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);
  import tar_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [W-1:0]  slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full     = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/tar_back.sv
`default_nettype none
module tar_back #(
  parameter int STORE_DEPTH = tar_pkg::STORE_DEPTH_DEF,
  parameter int AW          = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  output logic                      pop,
  input  wire tar_pkg::tar_flags_t  q_flags,
  input  wire logic [AW-1:0]        q_addr,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_value,
  output logic                      out_last,
  output logic                      span_error
);
  import tar_pkg::*;

  logic       store_r [STORE_DEPTH];
  logic       a_valid_r, rd_r, fw_r, fwv_r;
  tar_flags_t a_fl_r;
  logic [AW-1:0] a_addr_r;
  logic       out_valid_r, out_value_r, out_last_r, out_err_r;
  logic       a_leave, a_load, prev_v, v;

  assign prev_v  = fw_r ? fwv_r : rd_r;
  assign v       = a_fl_r.first ? a_fl_r.elem : (prev_v & a_fl_r.elem);
  assign a_leave = a_valid_r && (!a_fl_r.last || !out_valid_r || out_ready);
  assign a_load  = (!a_valid_r || a_leave) && !q_empty;
  assign pop     = a_load;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;
  assign span_error = out_err_r;

  // read-modify-write of the partial store, write on leave, read on load
  always_ff @(posedge clk) begin
    if (a_leave && a_fl_r.ok) begin
      store_r[a_addr_r] <= v;
    end
    if (a_load && q_flags.ok) begin
      rd_r <= store_r[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_fl_r   <= q_flags;
      a_addr_r <= q_addr;
      fw_r     <= a_leave && a_fl_r.ok && (a_addr_r == q_addr);
      fwv_r    <= v;
    end
    if (a_leave && a_fl_r.last) begin
      out_value_r <= a_fl_r.ok & v;
      out_last_r  <= a_fl_r.tend;
      out_err_r   <= !a_fl_r.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= 1'b1;
      end else if (a_leave) begin
        a_valid_r <= 1'b0;
      end
      if (a_leave && a_fl_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/tensor_axis_and_reduce_top.sv
`default_nettype none
// Streaming logical AND over the chosen axes of a boolean NCHW tensor, one
// element per item, w fastest. One item is taken per clock unless the queue
// is full or the input is held off; each result is registered through the
// queue, the back-end stage and the output register onto out_tvalid, in output
// layout order, and a full tensor yields its outputs with out_tlast on the
// final one. The partial-AND store is read when an item enters the back end
// and written as it leaves, with the preceding write forwarded, so the
// store sustains one item per cycle while out_tready does not hold it back.
// After reset and after each configuration write the input holds off while
// the span product settles; every register write starts a new tensor. When
// the span of kept positions exceeds STORE_DEPTH each result reads 0 with
// the error flag in out_tuser set.
module tensor_axis_and_reduce_top #(
  parameter int STORE_DEPTH = tar_pkg::STORE_DEPTH_DEF,
  parameter int DIM_BITS    = tar_pkg::DIM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tar_pkg::DIM_REG_W-1:0]  cfg_data,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [tar_pkg::TDATA_W-1:0]    in_tdata,  // [0] element_bit
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [tar_pkg::TDATA_W-1:0]         out_tdata, // [0] out_value
  output logic                                out_tlast,
  output logic [0:0]                          out_tuser  // [0] span_error
);
  import tar_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int QW = AW + FLAGS_W;

  logic          push, q_full, q_empty, pop, out_value, span_error;
  tar_flags_t    push_flags, q_flags;
  logic [AW-1:0] push_addr, q_addr;
  logic [QW-1:0] q_out;

  tar_front #(
    .STORE_DEPTH(STORE_DEPTH),
    .DIM_BITS   (DIM_BITS),
    .AW         (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_bit    (in_tdata[0]),
    .q_full    (q_full),
    .push      (push),
    .push_flags(push_flags),
    .push_addr (push_addr)
  );

  tar_queue #(
    .W(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_addr, push_flags}),
    .full     (q_full),
    .pop      (pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  assign q_flags = q_out[FLAGS_W-1:0];
  assign q_addr  = q_out[QW-1:FLAGS_W];

  tar_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .pop       (pop),
    .q_flags   (q_flags),
    .q_addr    (q_addr),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_value),
    .out_last  (out_tlast),
    .span_error(span_error)
  );

  assign out_tdata = {{(TDATA_W-1){1'b0}}, out_value};
  assign out_tuser = span_error;

endmodule
`default_nettype wire
